### rtl/gnnr_pkg.sv
// ----------------------------------------------------------------------------
// Grid rescale package
// Shared widths, payload types, register indexes and reset constants of the
// nearest-neighbor grid rescale unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gnnr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COORD_W     = 15;
   localparam int DIM_CFG_W   = 13;
   localparam int FACTOR_W    = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [COORD_W-1:0] coord_type;

   localparam sample_type MIN_RESET = 16'sh7fff;
   localparam sample_type MAX_RESET = 16'sh8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH,
      CSR_SRC_HEIGHT,
      CSR_SHRINK_MODE,
      CSR_FACTOR
   } csr_index_type;

   typedef struct packed {
      logic step;
      logic wrap;
   } axis_ctl_type;

endpackage

`default_nettype wire

### rtl/gnnr_req_if.sv
// ----------------------------------------------------------------------------
// Source sample channel
// Valid/ready channel that carries one source elevation sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gnnr_req_if
   import gnnr_pkg::*;
   ;
   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### rtl/gnnr_rsp_if.sv
// ----------------------------------------------------------------------------
// Destination cell channel
// Valid/ready channel that carries one destination cell per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gnnr_rsp_if
   import gnnr_pkg::*;
   ;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   coord_type  dest_row;
   coord_type  dest_col;
   sample_type running_min;
   sample_type running_max;
   logic       last_of_run;

   modport source (
      output valid, output sample_out, output dest_row, output dest_col,
      output running_min, output running_max, output last_of_run,
      input ready
   );
   modport sink (
      input valid, input sample_out, input dest_row, input dest_col,
      input running_min, input running_max, input last_of_run,
      output ready
   );
endinterface

`default_nettype wire

### rtl/grid_nearest_neighbor_rescale_unit.sv
// ----------------------------------------------------------------------------
// Grid nearest-neighbor rescale unit
// Source samples enter on req_chan in row-major order; the unit tracks the
// source row and column itself. Grow mode replicates each sample into a
// factor-by-factor block of destination cells; shrink mode keeps a sample
// only when its row and column are multiples of the factor. Every cell on
// rsp_chan carries the running minimum and maximum of the samples used so
// far in the current grid, and last_of_run marks the final cell of a sample.
// Registers are written through csr_we/csr_index/csr_wdata; the user must write
// them only while idle, as the block does not enforce it. A sample's cells pass
// through the work stage and then the output register. Cells leave the output
// register at one per cycle while the receiver is ready, so a grow sample yields
// factor*factor cells and a shrink sample one; a dropped sample yields no cell.
// The next sample is taken in the cycle its predecessor's last cell moves
// to the output register. A stalled receiver holds the output register and,
// behind it, the cell in progress and the input side. Reset empties both
// stages, zeroes the position, restarts min/max and loads width and height
// 4096, grow mode and factor 1; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_nearest_neighbor_rescale_unit
   import gnnr_pkg::*;
#(
   parameter int MAX_DIM    = 4096,
   parameter int MAX_FACTOR = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   gnnr_req_if.sink                    req_chan,
   gnnr_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int RW = $clog2(MAX_FACTOR);
   localparam int PW = CW + FACTOR_W;

   // configuration
   logic [DIM_CFG_W-1:0] src_width_ff, src_height_ff;
   logic                 shrink_mode_ff;
   logic [FACTOR_W-1:0]  factor_ff;

   logic [FACTOR_W-1:0]  f_eff;
   logic [DW-1:0]        w_eff, h_eff;

   // position tracking
   axis_ctl_type  row_ctl, col_ctl;
   logic [CW-1:0] row_count, col_count, row_quot, col_quot;
   logic          row_on, col_on;
   logic          col_end, row_end, kept;
   logic [PW-1:0] row_scaled, col_scaled;

   // running extremes
   sample_type min_seen_ff, min_seen_in, max_seen_ff, max_seen_in;
   sample_type min_upd, max_upd;

   // work stage
   logic          work_valid_ff, work_valid_in;
   sample_type    work_sample_ff, work_sample_in;
   sample_type    work_min_ff, work_min_in, work_max_ff, work_max_in;
   coord_type     work_row_ff, work_row_in, work_col_ff, work_col_in;
   logic [RW-1:0] work_lim_ff, work_lim_in, work_r_ff, work_r_in, work_c_ff, work_c_in;

   // output stage
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_sample_ff, rsp_sample_in, rsp_min_ff, rsp_min_in, rsp_max_ff, rsp_max_in;
   coord_type  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic       rsp_last_ff, rsp_last_in;

   logic accept, load, out_free, emit, c_last, r_last, item_last, work_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= DIM_CFG_W'(4096);
         src_height_ff  <= DIM_CFG_W'(4096);
         shrink_mode_ff <= 1'b0;
         factor_ff      <= FACTOR_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH:   src_width_ff   <= csr_wdata;
            CSR_SRC_HEIGHT:  src_height_ff  <= csr_wdata;
            CSR_SHRINK_MODE: shrink_mode_ff <= csr_wdata[0];
            CSR_FACTOR:      factor_ff      <= csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (factor_ff == '0) begin
         f_eff = FACTOR_W'(1);
      end else if (int'(factor_ff) > MAX_FACTOR) begin
         f_eff = FACTOR_W'(MAX_FACTOR);
      end else begin
         f_eff = factor_ff;
      end

      if (src_width_ff == '0) begin
         w_eff = DW'(1);
      end else if (int'(src_width_ff) > MAX_DIM) begin
         w_eff = DW'(MAX_DIM);
      end else begin
         w_eff = DW'(src_width_ff);
      end

      if (src_height_ff == '0) begin
         h_eff = DW'(1);
      end else if (int'(src_height_ff) > MAX_DIM) begin
         h_eff = DW'(MAX_DIM);
      end else begin
         h_eff = DW'(src_height_ff);
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = work_valid_ff && out_free;
   assign c_last    = (work_c_ff == work_lim_ff);
   assign r_last    = (work_r_ff == work_lim_ff);
   assign item_last = c_last && r_last;
   assign work_done = emit && item_last;

   assign req_chan.ready = !work_valid_ff || work_done;
   assign accept         = req_chan.valid && req_chan.ready;

   // position
   assign col_end = (DW'(col_count) + DW'(1)) >= w_eff;
   assign row_end = (DW'(row_count) + DW'(1)) >= h_eff;

   assign col_ctl.step = accept;
   assign col_ctl.wrap = col_end;
   assign row_ctl.step = accept && col_end;
   assign row_ctl.wrap = row_end;

   gnnr_axis_count #(
      .CW         (CW),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_row_count (
      .clock   (clock),
      .reset   (reset),
      .ctl     (row_ctl),
      .factor  (f_eff),
      .count   (row_count),
      .quot    (row_quot),
      .on_grid (row_on)
   );

   gnnr_axis_count #(
      .CW         (CW),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_col_count (
      .clock   (clock),
      .reset   (reset),
      .ctl     (col_ctl),
      .factor  (f_eff),
      .count   (col_count),
      .quot    (col_quot),
      .on_grid (col_on)
   );

   assign kept = !shrink_mode_ff || (row_on && col_on);
   assign load = accept && kept;

   assign row_scaled = PW'(row_count) * PW'(f_eff);
   assign col_scaled = PW'(col_count) * PW'(f_eff);

   // running extremes
   always_comb begin
      min_upd = (req_chan.sample_in < min_seen_ff) ? req_chan.sample_in : min_seen_ff;
      max_upd = (req_chan.sample_in > max_seen_ff) ? req_chan.sample_in : max_seen_ff;

      min_seen_in = min_seen_ff;
      max_seen_in = max_seen_ff;
      if (accept) begin
         if (col_end && row_end) begin
            min_seen_in = MIN_RESET;
            max_seen_in = MAX_RESET;
         end else if (kept) begin
            min_seen_in = min_upd;
            max_seen_in = max_upd;
         end
      end
   end

   // work stage: load a kept sample, then step through its cells
   always_comb begin
      work_valid_in  = work_valid_ff;
      work_sample_in = work_sample_ff;
      work_min_in    = work_min_ff;
      work_max_in    = work_max_ff;
      work_row_in    = work_row_ff;
      work_col_in    = work_col_ff;
      work_lim_in    = work_lim_ff;
      work_r_in      = work_r_ff;
      work_c_in      = work_c_ff;

      if (load) begin
         work_valid_in  = 1'b1;
         work_sample_in = req_chan.sample_in;
         work_min_in    = min_upd;
         work_max_in    = max_upd;
         work_r_in      = '0;
         work_c_in      = '0;
         if (shrink_mode_ff) begin
            work_row_in = COORD_W'(row_quot);
            work_col_in = COORD_W'(col_quot);
            work_lim_in = '0;
         end else begin
            work_row_in = COORD_W'(row_scaled);
            work_col_in = COORD_W'(col_scaled);
            work_lim_in = RW'(f_eff - FACTOR_W'(1));
         end
      end else if (work_done) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         if (c_last) begin
            work_c_in = '0;
            work_r_in = work_r_ff + RW'(1);
         end else begin
            work_c_in = work_c_ff + RW'(1);
         end
      end
   end

   // output stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = work_sample_ff;
         rsp_row_in    = work_row_ff + COORD_W'(work_r_ff);
         rsp_col_in    = work_col_ff + COORD_W'(work_c_ff);
         rsp_min_in    = work_min_ff;
         rsp_max_in    = work_max_ff;
         rsp_last_in   = item_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_seen_ff   <= MIN_RESET;
         max_seen_ff   <= MAX_RESET;
         work_valid_ff <= 1'b0;
         work_r_ff     <= '0;
         work_c_ff     <= '0;
         work_lim_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         min_seen_ff   <= min_seen_in;
         max_seen_ff   <= max_seen_in;
         work_valid_ff <= work_valid_in;
         work_r_ff     <= work_r_in;
         work_c_ff     <= work_c_in;
         work_lim_ff   <= work_lim_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_sample_ff <= work_sample_in;
      work_min_ff    <= work_min_in;
      work_max_ff    <= work_max_in;
      work_row_ff    <= work_row_in;
      work_col_ff    <= work_col_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_min_ff     <= rsp_min_in;
      rsp_max_ff     <= rsp_max_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sample_out  = rsp_sample_ff;
   assign rsp_chan.dest_row    = rsp_row_ff;
   assign rsp_chan.dest_col    = rsp_col_ff;
   assign rsp_chan.running_min = rsp_min_ff;
   assign rsp_chan.running_max = rsp_max_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/gnnr_axis_count.sv
// ----------------------------------------------------------------------------
// Grid axis counter
// Source row or column position, with one remainder/quotient lane per
// scale factor so that the divided position and the on-grid flag for the
// current factor are read out without a divider.
// ----------------------------------------------------------------------------
`default_nettype none

module gnnr_axis_count
   import gnnr_pkg::*;
#(
   parameter int CW         = 12,
   parameter int MAX_FACTOR = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire axis_ctl_type        ctl,
   input  wire logic [FACTOR_W-1:0] factor,
   output logic      [CW-1:0]       count,
   output logic      [CW-1:0]       quot,
   output logic                     on_grid
);

   localparam int RW = $clog2(MAX_FACTOR);

   logic [CW-1:0] count_ff, count_in;
   logic [RW-1:0] rem_ff [MAX_FACTOR];
   logic [RW-1:0] rem_in [MAX_FACTOR];
   logic [CW-1:0] quot_ff [MAX_FACTOR];
   logic [CW-1:0] quot_in [MAX_FACTOR];
   logic [RW-1:0] lane;

   always_comb begin
      count_in = count_ff;
      if (ctl.step) begin
         if (ctl.wrap) begin
            count_in = '0;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   // lane i tracks division by i+1
   always_comb begin
      for (int i = 0; i < MAX_FACTOR; i++) begin
         rem_in[i]  = rem_ff[i];
         quot_in[i] = quot_ff[i];
         if (ctl.step) begin
            if (ctl.wrap) begin
               rem_in[i]  = '0;
               quot_in[i] = '0;
            end else if (({1'b0, rem_ff[i]} + (RW+1)'(1)) == (RW+1)'(i + 1)) begin
               rem_in[i]  = '0;
               quot_in[i] = quot_ff[i] + CW'(1);
            end else begin
               rem_in[i] = rem_ff[i] + RW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < MAX_FACTOR; i++) begin
            rem_ff[i]  <= '0;
            quot_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < MAX_FACTOR; i++) begin
            rem_ff[i]  <= rem_in[i];
            quot_ff[i] <= quot_in[i];
         end
      end
   end

   assign lane    = RW'(factor - FACTOR_W'(1));
   assign count   = count_ff;
   assign quot    = quot_ff[lane];
   assign on_grid = (rem_ff[lane] == '0);

endmodule

`default_nettype wire

### dv/tb_grid_nearest_neighbor_rescale_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid rescale unit testbench
// Drives source samples into the rescale unit and checks every destination
// cell against an in-bench model of grow and shrink scaling, grid tracking
// and the running min/max. The run opens with a stimulus table, then runs
// random register settings and samples under four idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_grid_nearest_neighbor_rescale_unit
   import gnnr_pkg::*;
   ;

   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DIM_MAX         = 4096;
   localparam int FACTOR_MAX      = 8;
   localparam int SEGMENTS        = 5;
   localparam int SEGMENT_SAMPLES = 19;

   typedef struct packed {
      sample_type sample_out;
      coord_type  dest_row;
      coord_type  dest_col;
      sample_type running_min;
      sample_type running_max;
      logic       last_of_run;
   } dest_cell_type;

   typedef enum logic {STEP_SAMPLE, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      csr_index_type         reg_sel;
      logic [CSR_DATA_W-1:0] reg_value;
      sample_type            sample;
      logic                  typed;
      dest_cell_type         exp_cell;
   } directed_step_type;

   localparam dest_cell_type NO_CELL = '0;
   localparam int DIRECTED_STEPS = 34;

   localparam directed_step_type DIRECTED [DIRECTED_STEPS] = '{
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh7fff, 1'b1,
        '{16'sh7fff, 15'd0, 15'd0, 16'sh7fff, 16'sh7fff, 1'b1}},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh8000, 1'b1,
        '{16'sh8000, 15'd0, 15'd1, 16'sh8000, 16'sh7fff, 1'b1}},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_SRC_WIDTH, 13'd3, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_SRC_HEIGHT, 13'd2, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_FACTOR, 13'd0, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh0064, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_FACTOR, 13'd15, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'shfffb, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh0007, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh0009, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh04d2, 1'b1,
        '{16'sh04d2, 15'd0, 15'd0, 16'sh04d2, 16'sh04d2, 1'b0}},
      '{STEP_CSR, CSR_SHRINK_MODE, 13'd1, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_FACTOR, 13'd2, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_SRC_WIDTH, 13'd5, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_SRC_HEIGHT, 13'd4, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh0001, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh0002, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh8001, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh7ffe, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh5555, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'shaaaa, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh00ff, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'shff00, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_SRC_WIDTH, 13'd0, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_SRC_HEIGHT, 13'd0, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh1111, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'shffff, 1'b1,
        '{16'shffff, 15'd0, 15'd0, 16'shffff, 16'shffff, 1'b1}},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh8000, 1'b1,
        '{16'sh8000, 15'd0, 15'd0, 16'sh8000, 16'sh8000, 1'b1}},
      '{STEP_CSR, CSR_SRC_WIDTH, 13'h1fff, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_SRC_HEIGHT, 13'h1fff, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_SHRINK_MODE, 13'd0, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_CSR, CSR_FACTOR, 13'd1, 16'sh0000, 1'b0, NO_CELL},
      '{STEP_SAMPLE, CSR_SRC_WIDTH, 13'd0, 16'sh7fff, 1'b1,
        '{16'sh7fff, 15'd0, 15'd0, 16'sh7fff, 16'sh7fff, 1'b1}}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   gnnr_req_if req_chan ();
   gnnr_rsp_if rsp_chan ();

   grid_nearest_neighbor_rescale_unit #(
      .MAX_DIM(DIM_MAX),
      .MAX_FACTOR(FACTOR_MAX)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // model copy of the registers and the grid position
   logic [DIM_CFG_W-1:0] width_reg;
   logic [DIM_CFG_W-1:0] height_reg;
   logic                 shrink_reg;
   logic [FACTOR_W-1:0]  factor_reg;
   int unsigned          src_row;
   int unsigned          src_col;
   sample_type           low_mark;
   sample_type           high_mark;
   dest_cell_type        cells_due [$];
   dest_cell_type        head_cell;

   int   send_idle_pct;
   int   recv_stall_pct;
   bit   hold_request;
   int   hold_left;
   int   errors;
   int   samples_sent;
   int   cells_checked;
   int   csr_writes;
   int   cycle_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input logic [DIM_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_MAX) return DIM_MAX;
      return 32'(v);
   endfunction

   task automatic rescale_sample(input sample_type s);
      int unsigned   f;
      int unsigned   w;
      int unsigned   h;
      int unsigned   r;
      int unsigned   c;
      dest_cell_type next_cell;
      f = (factor_reg == 0) ? 1 : (factor_reg > FACTOR_MAX) ? FACTOR_MAX : 32'(factor_reg);
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      if (!shrink_reg || (src_row % f == 0 && src_col % f == 0)) begin
         if (s < low_mark) low_mark = s;
         if (s > high_mark) high_mark = s;
         next_cell.sample_out  = s;
         next_cell.running_min = low_mark;
         next_cell.running_max = high_mark;
         if (shrink_reg) begin
            next_cell.dest_row    = coord_type'(src_row / f);
            next_cell.dest_col    = coord_type'(src_col / f);
            next_cell.last_of_run = 1'b1;
            cells_due.push_back(next_cell);
         end else begin
            for (r = 0; r < f; r++) begin
               for (c = 0; c < f; c++) begin
                  next_cell.dest_row    = coord_type'(src_row * f + r);
                  next_cell.dest_col    = coord_type'(src_col * f + c);
                  next_cell.last_of_run = (r == f - 1) && (c == f - 1);
                  cells_due.push_back(next_cell);
               end
            end
         end
      end
      // advance the source position; close the grid after its last row
      if (src_col + 1 >= w) begin
         src_col = 0;
         if (src_row + 1 >= h) begin
            src_row   = 0;
            low_mark  = MIN_RESET;
            high_mark = MAX_RESET;
         end else begin
            src_row++;
         end
      end else begin
         src_col++;
      end
   endtask

   task automatic send_sample(input sample_type s, input logic typed,
                              input dest_cell_type typed_cell);
      int          gap;
      int unsigned first;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_we             <= 1'b0;
      req_chan.valid     <= 1'b1;
      req_chan.sample_in <= s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      first = cells_due.size();
      rescale_sample(s);
      if (typed && cells_due.size() > first) cells_due[first] = typed_cell;
      samples_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      csr_we         <= 1'b0;
      do @(posedge clock); while (cells_due.size() != 0);
      // let a trailing dropped sample finish
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SRC_WIDTH:   width_reg  = value;
         CSR_SRC_HEIGHT:  height_reg = value;
         CSR_SHRINK_MODE: shrink_reg = value[0];
         CSR_FACTOR:      factor_reg = value[FACTOR_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                            input logic shrink, input logic [FACTOR_W-1:0] f);
      drain();
      write_csr(CSR_SRC_WIDTH, w);
      write_csr(CSR_SRC_HEIGHT, h);
      write_csr(CSR_SHRINK_MODE, CSR_DATA_W'(shrink));
      write_csr(CSR_FACTOR, CSR_DATA_W'(f));
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'shffff;
         default: return sample_type'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [DIM_CFG_W-1:0] pick_dim();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 13'd4096;
         2:       return 13'h1fff;
         3:       return DIM_CFG_W'($urandom_range(4097, 8190));
         default: return DIM_CFG_W'($urandom_range(1, 9));
      endcase
   endfunction

   function automatic logic [FACTOR_W-1:0] pick_factor();
      case ($urandom_range(7))
         0:       return '0;
         1:       return FACTOR_W'($urandom_range(9, 15));
         2:       return 4'd8;
         default: return FACTOR_W'($urandom_range(1, 4));
      endcase
   endfunction

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_OFF_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (cells_due.size() == 0) begin
            $error("cell with nothing pending: row %0d col %0d",
                   rsp_chan.dest_row, rsp_chan.dest_col);
            errors++;
         end else begin
            head_cell = cells_due.pop_front();
            cells_checked++;
            if (rsp_chan.sample_out !== head_cell.sample_out) begin
               $error("sample_out: expected %0d, got %0d",
                      $signed(head_cell.sample_out), $signed(rsp_chan.sample_out));
               errors++;
            end
            if (rsp_chan.dest_row !== head_cell.dest_row) begin
               $error("dest_row: expected %0d, got %0d", head_cell.dest_row, rsp_chan.dest_row);
               errors++;
            end
            if (rsp_chan.dest_col !== head_cell.dest_col) begin
               $error("dest_col: expected %0d, got %0d", head_cell.dest_col, rsp_chan.dest_col);
               errors++;
            end
            if (rsp_chan.running_min !== head_cell.running_min) begin
               $error("running_min: expected %0d, got %0d",
                      $signed(head_cell.running_min), $signed(rsp_chan.running_min));
               errors++;
            end
            if (rsp_chan.running_max !== head_cell.running_max) begin
               $error("running_max: expected %0d, got %0d",
                      $signed(head_cell.running_max), $signed(rsp_chan.running_max));
               errors++;
            end
            if (rsp_chan.last_of_run !== head_cell.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b",
                      head_cell.last_of_run, rsp_chan.last_of_run);
               errors++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_grid_nearest_neighbor_rescale_unit: done, errors");
      $finish;
   end

   initial begin
      int i;
      int phase;
      int seg;
      int k;
      req_chan.valid     = 1'b0;
      req_chan.sample_in = '0;
      rsp_chan.ready     = 1'b0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      hold_request       = 1'b0;
      hold_left          = 0;
      errors             = 0;
      samples_sent       = 0;
      cells_checked      = 0;
      csr_writes         = 0;
      width_reg          = 13'd4096;
      height_reg         = 13'd4096;
      shrink_reg         = 1'b0;
      factor_reg         = 4'd1;
      src_row            = 0;
      src_col            = 0;
      low_mark           = MIN_RESET;
      high_mark          = MAX_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIRECTED_STEPS; i++) begin
         if (DIRECTED[i].kind == STEP_CSR) begin
            drain();
            write_csr(DIRECTED[i].reg_sel, DIRECTED[i].reg_value);
         end else begin
            send_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].exp_cell);
         end
      end

      for (phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         for (seg = 0; seg < SEGMENTS; seg++) begin
            if (phase == 0 && seg == 0) begin
               // hold the receiver off while grow samples pile up behind it
               configure(13'd4, 13'd4, 1'b0, 4'd4);
               hold_request = 1'b1;
            end else begin
               configure(pick_dim(), pick_dim(), 1'($urandom_range(1)), pick_factor());
            end
            for (k = 0; k < SEGMENT_SAMPLES; k++) send_sample(pick_sample(), 1'b0, NO_CELL);
         end
      end

      drain();
      $display("rescale run: %0d samples sent, %0d cells checked, %0d register writes",
               samples_sent, cells_checked, csr_writes);
      $display("grow and shrink, factors 0-15, sizes 0-8191, idle and stall mixes, hold-off");
      if (errors == 0) begin
         $display("tb_grid_nearest_neighbor_rescale_unit: done, clean");
      end else begin
         $display("tb_grid_nearest_neighbor_rescale_unit: done, errors");
      end
      $finish;
   end

endmodule

### files.f
rtl/gnnr_pkg.sv
rtl/gnnr_req_if.sv
rtl/gnnr_rsp_if.sv
rtl/gnnr_axis_count.sv
rtl/grid_nearest_neighbor_rescale_unit.sv
dv/tb_grid_nearest_neighbor_rescale_unit.sv
